/* src/wesm_pkg.sv */
// Shared types, constants and a helper function of the wheel encoder speed meter.
package wesm_pkg;

   // Field widths of the channels.
   localparam int ELAPSED_W   = 16;
   localparam int SPEED_W     = 9;
   localparam int POSITION_W  = 17;
   localparam int OUT_COUNT_W = 32;
   localparam int CPR_W       = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // Internal position counter carries one extra bit for the step past the limit.
   localparam int POS_W = POSITION_W + 1;

   // Only magnitudes below twice the elapsed time reach the divider.
   localparam int MAG_W      = ELAPSED_W + 1;
   localparam int QUO_W      = 9;
   localparam int DIVIDEND_W = QUO_W + ELAPSED_W;
   localparam int SCALE_SH   = 8;
   localparam int DIV_STEPS  = QUO_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [QUO_W-1:0] SPEED_MAX = QUO_W'(255);

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_PER_REV    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_DIRECTION = CSR_INDEX_W'(1);

   localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(1250);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Clamp an unsigned quotient to the speed limit and apply the sign.
   function automatic logic signed [SPEED_W-1:0] signed_speed(
      input logic [QUO_W-1:0] quo,
      input logic             neg
   );
      logic [QUO_W-1:0] sat;
      sat = (quo > SPEED_MAX) ? SPEED_MAX : quo;
      return neg ? SPEED_W'(-$signed({1'b0, sat})) : SPEED_W'(sat);
   endfunction

endpackage

/* src/wesm_if.sv */
// Channel interfaces of the wheel encoder speed meter: request, response, register write.
interface wesm_req_if import wesm_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic                 chan_a;
   logic                 chan_b;
   logic [ELAPSED_W-1:0] elapsed_ms;

   modport source (output valid, op, chan_a, chan_b, elapsed_ms, input ready);
   modport sink   (input valid, op, chan_a, chan_b, elapsed_ms, output ready);
endinterface

interface wesm_rsp_if import wesm_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_W-1:0]     speed;
   logic signed [POSITION_W-1:0]  position;
   logic signed [OUT_COUNT_W-1:0] revolutions;
   logic signed [OUT_COUNT_W-1:0] total_ticks;

   modport source (output valid, speed, position, revolutions, total_ticks, input ready);
   modport sink   (input valid, speed, position, revolutions, total_ticks, output ready);
endinterface

interface wesm_csr_if import wesm_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* src/wesm_div.sv */
// Bit-serial restoring divider that produces one quotient bit per cycle.
module wesm_div import wesm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [ELAPSED_W-1:0]  divisor,
   output logic [QUO_W-1:0]      quotient,
   output div_status_type        status
);

   logic [ELAPSED_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]     shift_ff, shift_in;
   logic [ELAPSED_W-1:0] div_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [ELAPSED_W:0]   trial;
   logic [ELAPSED_W:0]   trial_diff;
   logic                 fits;

   // The caller guarantees that the upper dividend bits are below the divisor,
   // so the quotient fits in QUO_W bits.
   always_comb begin
      trial      = {rem_ff, shift_ff[QUO_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      fits       = trial >= {1'b0, div_ff};
      rem_in     = fits ? trial_diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
      shift_in   = {shift_ff[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff   <= dividend[DIVIDEND_W-1:QUO_W];
            shift_ff <= dividend[QUO_W-1:0];
            div_ff   <= divisor;
            step_ff  <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            shift_ff <= shift_in;
            step_ff  <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = shift_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* src/wheel_encoder_speed_meter.sv */
// Top level of the wheel encoder speed meter: edge counting, revolution tracking, speed.
//
// Usage. Each request transaction on req_bus is either an encoder edge (op = 0, with the
// levels of channels A and B) or a speed sample (op = 1, with the milliseconds elapsed
// since the previous sample). Every request yields exactly one response transaction on
// rsp_bus, carrying the speed, the position within the revolution, the revolution count
// and the total tick count, all as they stand after the request was applied.
// Register writes on csr_bus set the counts per revolution (index 0) and the direction
// inversion (index 1); they are always taken and must only arrive while the block is idle.
//
// Timing. An edge request passes from the idle state straight to the done state, and the
// block takes the next request only once it is back in idle. A sample request runs through
// the prepare state to done when the result saturates or is zero; otherwise it waits in the
// divide state for the nine steps of the bit-serial divider that forms change * 255 / elapsed_ms.
//
// The response sits in an output register, so a new request is accepted while the previous
// response waits; if the receiver stalls, the finished result of the next request is held
// back until the output register frees up. Reset clears all counters and the speed and
// restores the register defaults (1250 counts per revolution, normal direction).
module wheel_encoder_speed_meter import wesm_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   wesm_req_if.sink   req_bus,
   wesm_rsp_if.source rsp_bus,
   wesm_csr_if.sink   csr_bus
);

   // Zero-extended magnitude width, wide enough to pick out the low divider bits.
   localparam int EXT_W = (COUNT_WIDTH > MAG_W) ? COUNT_WIDTH : MAG_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   // Configuration registers.
   logic [CPR_W-1:0] cpr_ff;
   logic             invert_ff;

   // Counter state.
   logic signed [POS_W-1:0]   pos_ff;
   logic [COUNT_WIDTH-1:0]    rev_ff;
   logic [COUNT_WIDTH-1:0]    tick_ff;
   logic [COUNT_WIDTH-1:0]    last_tick_ff;
   logic signed [SPEED_W-1:0] speed_ff;

   // Sample work registers.
   logic [COUNT_WIDTH-1:0] diff_ff;
   logic [ELAPSED_W-1:0]   elapsed_ff;
   logic                   neg_ff;

   // Response output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0]     rsp_speed_ff;
   logic signed [POSITION_W-1:0]  rsp_position_ff;
   logic signed [OUT_COUNT_W-1:0] rsp_revolutions_ff;
   logic signed [OUT_COUNT_W-1:0] rsp_total_ticks_ff;

   logic req_take;
   logic edge_take;
   logic sample_take;
   logic rsp_load;

   // Edge step logic.
   logic                    step_up;
   logic signed [POS_W-1:0] pos_step;
   logic signed [POS_W-1:0] lim_pos;
   logic signed [POS_W-1:0] lim_neg;
   logic                    pos_wrap;

   // Sample preparation logic.
   logic                   diff_neg;
   logic [COUNT_WIDTH-1:0] mag;
   logic [EXT_W-1:0]       mag_ext;
   logic [MAG_W-1:0]       mag_low;
   logic                   mag_zero;
   logic                   saturate;
   logic [DIVIDEND_W-1:0]  dividend;
   logic                   div_start;
   logic [QUO_W-1:0]       quotient;
   div_status_type         div_status;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign req_take    = req_bus.valid && req_bus.ready;
   assign edge_take   = req_take && !req_bus.op;
   assign sample_take = req_take && req_bus.op;

   // A channel match counts up; the inversion bit mirrors the sense for the other wheel.
   // The limit test runs on the stepped position, so a lowered limit wraps on the next
   // outward edge.
   always_comb begin
      step_up  = (req_bus.chan_a == req_bus.chan_b) ^ invert_ff;
      pos_step = step_up ? (pos_ff + POS_W'(1)) : (pos_ff - POS_W'(1));
      lim_pos  = $signed({{(POS_W - CPR_W){1'b0}}, cpr_ff});
      lim_neg  = -lim_pos;
      pos_wrap = step_up ? (pos_step > lim_pos) : (pos_step < lim_neg);
   end

   // A magnitude of at least twice the elapsed time gives at least 510 before clamping,
   // so it saturates outright. Anything smaller keeps the quotient below 512 and
   // the scaled dividend below 2^25.
   always_comb begin
      diff_neg = diff_ff[COUNT_WIDTH-1];
      mag      = diff_neg ? (COUNT_WIDTH'(0) - diff_ff) : diff_ff;
      mag_ext  = EXT_W'(mag);
      mag_low  = mag_ext[MAG_W-1:0];
      mag_zero = (mag == '0);
      saturate = (elapsed_ff == '0) || ((mag_ext >> MAG_W) != '0)
                 || (mag_low >= {elapsed_ff, 1'b0});
      dividend = (DIVIDEND_W'(mag_low) << SCALE_SH) - DIVIDEND_W'(mag_low);
   end

   assign div_start = (state_ff == S_PREP) && !mag_zero && !saturate;

   wesm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (elapsed_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   // In the done state, the result register loads when it is empty or its transaction completes now.
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (edge_take) begin
               state_in = S_DONE;
            end else if (sample_take) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = div_start ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cpr_ff       <= CPR_RESET;
         invert_ff    <= 1'b0;
         pos_ff       <= '0;
         rev_ff       <= '0;
         tick_ff      <= '0;
         last_tick_ff <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;

         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_COUNT_PER_REV:    cpr_ff    <= csr_bus.wdata[CPR_W-1:0];
               CSR_INVERT_DIRECTION: invert_ff <= csr_bus.wdata[0];
               default: ;
            endcase
         end

         if (edge_take) begin
            tick_ff <= step_up ? (tick_ff + COUNT_WIDTH'(1)) : (tick_ff - COUNT_WIDTH'(1));
            if (pos_wrap) begin
               pos_ff <= '0;
               rev_ff <= step_up ? (rev_ff + COUNT_WIDTH'(1)) : (rev_ff - COUNT_WIDTH'(1));
            end else begin
               pos_ff <= pos_step;
            end
         end

         if (sample_take) begin
            last_tick_ff <= tick_ff;
         end

         if (state_ff == S_PREP && !div_start) begin
            speed_ff <= mag_zero ? '0 : signed_speed(SPEED_MAX, diff_neg);
         end

         if (state_ff == S_DIV && div_status.done) begin
            speed_ff <= signed_speed(quotient, neg_ff);
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (sample_take) begin
         diff_ff    <= tick_ff - last_tick_ff;
         elapsed_ff <= req_bus.elapsed_ms;
      end
      if (state_ff == S_PREP) begin
         neg_ff <= diff_neg;
      end
      if (rsp_load) begin
         rsp_speed_ff       <= speed_ff;
         rsp_position_ff    <= pos_ff[POSITION_W-1:0];
         rsp_revolutions_ff <= OUT_COUNT_W'($signed(rev_ff));
         rsp_total_ticks_ff <= OUT_COUNT_W'($signed(tick_ff));
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.speed       = rsp_speed_ff;
   assign rsp_bus.position    = rsp_position_ff;
   assign rsp_bus.revolutions = rsp_revolutions_ff;
   assign rsp_bus.total_ticks = rsp_total_ticks_ff;

   // The divider must be running or just finishing whenever the sequencer waits on it.
   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_status.busy || div_status.done))
      else $error("sequencer waits on an idle divider");

   // The wrap logic keeps the stored position within one revolution of the largest limit.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= $signed(POS_W'(65535))) && (pos_ff >= $signed(-POS_W'(65535))))
      else $error("position counter out of range");

   // The only code outside the speed range is the most negative nine-bit value.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff != $signed({1'b1, {(SPEED_W - 1){1'b0}}}))
      else $error("speed outside the clamp range");

   // The tick counter moves only on an accepted edge transaction.
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      !edge_take |=> $stable(tick_ff))
      else $error("tick counter changed without an edge");

   // A finished result always reaches the output register.
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result loaded but response not valid");

endmodule
